[src/atoe_pkg.sv]
// ----------------------------------------------------------------------------
// atoe_pkg: shared types and constants for the address table
// Field widths, transfer layouts, the search token that walks the cell
// chain, the write command broadcast to the cells and the control states.
// ----------------------------------------------------------------------------
package atoe_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 48;
    localparam int TYPE_W      = 2;
    localparam int STR_W       = 8;
    localparam int TIME_W      = 32;
    localparam int RIDX_W      = 4;
    localparam int SLOT_W      = 4;
    localparam int FILL_W      = 5;
    localparam int CMP_W       = (IDX_W > RIDX_W) ? IDX_W : RIDX_W;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 104;

    localparam logic KIND_SIGHT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic              active;
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [TYPE_W-1:0] atype;
        logic [STR_W-1:0]  strength;
        logic [TIME_W-1:0] now;
        logic [RIDX_W-1:0] read_index;
        logic              hit;
        idx_t              hit_idx;
        logic [TIME_W-1:0] old_time;
        idx_t              old_idx;
        logic              rd_valid;
        logic [ADDR_W-1:0] rd_addr;
        logic [TYPE_W-1:0] rd_type;
        logic [STR_W-1:0]  rd_strength;
        logic [TIME_W-1:0] rd_seen;
    } token_t;

    typedef struct packed {
        logic              en;
        logic              new_addr;
        idx_t              slot;
        logic [ADDR_W-1:0] addr;
        logic [TYPE_W-1:0] atype;
        logic [STR_W-1:0]  strength;
        logic [TIME_W-1:0] now;
    } wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

endpackage

[src/atoe_cell.sv]
// ----------------------------------------------------------------------------
// atoe_cell: one table entry and one stage of the search chain
// Holds an entry, folds it into the passing token (match, oldest, read)
// and registers the token toward the next cell.
// ----------------------------------------------------------------------------
module atoe_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  atoe_pkg::idx_t   cell_idx,
    input  atoe_pkg::cnt_t   count,
    input  atoe_pkg::wr_t    wr,
    input  atoe_pkg::token_t tok_in,
    output atoe_pkg::token_t tok_out
);
    import atoe_pkg::*;

    logic [ADDR_W-1:0] addr_reg;
    logic [TYPE_W-1:0] type_reg;
    logic [STR_W-1:0]  str_reg;
    logic [TIME_W-1:0] seen_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic              in_use;

    always_comb begin
        in_use   = CNT_W'(cell_idx) < count;
        tok_next = tok_in;
        if (in_use && (tok_in.kind == KIND_SIGHT)) begin
            if (!tok_in.hit && (addr_reg == tok_in.addr)) begin
                tok_next.hit     = 1'b1;
                tok_next.hit_idx = cell_idx;
            end
            if (seen_reg < tok_in.old_time) begin
                tok_next.old_time = seen_reg;
                tok_next.old_idx  = cell_idx;
            end
        end
        if (in_use && (tok_in.kind == KIND_READ) &&
            (CMP_W'(cell_idx) == CMP_W'(tok_in.read_index))) begin
            tok_next.rd_valid    = 1'b1;
            tok_next.rd_addr     = addr_reg;
            tok_next.rd_type     = type_reg;
            tok_next.rd_strength = str_reg;
            tok_next.rd_seen     = seen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en && (wr.slot == cell_idx)) begin
            if (wr.new_addr) begin
                addr_reg <= wr.addr;
            end
            type_reg <= wr.atype;
            str_reg  <= wr.strength;
            seen_reg <= wr.now;
        end
    end

    assign tok_out = tok_reg;

endmodule

[src/address_table_oldest_eviction.sv]
// ----------------------------------------------------------------------------
// address_table_oldest_eviction: address learning table, oldest replaced
// Channel   Dir  Ports                      Content
// s_axis    in   tvalid tready tdata tuser   sighting or read request
// m_axis    out  tvalid tready tdata         one result per request
// A request walks a chain of TABLE_DEPTH cells, one cell per cycle, then
// commits; s_axis_tready is high only in the idle state, so a new request
// is taken only after the previous one has committed.
// Reset empties the table at once (fill count to zero); no clearing pass.
// A result waiting on m_axis holds the commit and, with it, s_axis_tready.
// ----------------------------------------------------------------------------
module address_table_oldest_eviction (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // device_address[47:0], address_type[49:48], signal_strength[57:50],
    // time_now[89:58], read_index[93:90], zero pad[95:94]
    input  logic [atoe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // slot[3:0], was_present[4], was_evicted[5], fill_count[10:6],
    // read_valid[11], read_address[59:12], read_address_type[61:60],
    // read_strength[69:62], read_last_seen[101:70], zero pad[103:102]
    output logic [atoe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import atoe_pkg::*;

    state_t                 state_reg, state_next;
    cnt_t                   count_reg, count_next;
    token_t                 res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    token_t                 tok_chain [0:TABLE_DEPTH];
    token_t                 tok_head;
    wr_t                    wr;
    logic                   accept;
    logic                   out_free;
    logic                   full;
    idx_t                   slot;
    logic                   evicted;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign full     = count_reg == CNT_W'(TABLE_DEPTH);

    always_comb begin
        tok_head             = '0;
        tok_head.active      = accept;
        tok_head.kind        = s_axis_tuser;
        tok_head.addr        = s_axis_tdata[47:0];
        tok_head.atype       = s_axis_tdata[49:48];
        tok_head.strength    = s_axis_tdata[57:50];
        tok_head.now         = s_axis_tdata[89:58];
        tok_head.read_index  = s_axis_tdata[93:90];
        tok_head.old_time    = '1;
    end

    assign tok_chain[0] = tok_head;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        atoe_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (idx_t'(i)),
            .count    (count_reg),
            .wr       (wr),
            .tok_in   (tok_chain[i]),
            .tok_out  (tok_chain[i+1])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        s_axis_tready = 1'b0;
        wr            = '0;
        wr.addr       = res_reg.addr;
        wr.atype      = res_reg.atype;
        wr.strength   = res_reg.strength;
        wr.now        = res_reg.now;
        slot          = res_reg.hit_idx;
        evicted       = 1'b0;

        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = aresetn;
                if (s_axis_tvalid) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (tok_chain[TABLE_DEPTH].active) begin
                    res_next   = tok_chain[TABLE_DEPTH];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (res_reg.kind == KIND_READ) begin
                        m_data_next = {2'b00, res_reg.rd_seen, res_reg.rd_strength,
                                       res_reg.rd_type, res_reg.rd_addr,
                                       res_reg.rd_valid, FILL_W'(count_reg),
                                       1'b0, 1'b0, SLOT_W'(0)};
                    end else begin
                        if (!res_reg.hit) begin
                            if (full) begin
                                slot    = res_reg.old_idx;
                                evicted = 1'b1;
                            end else begin
                                slot       = idx_t'(count_reg);
                                count_next = CNT_W'(count_reg + 1'b1);
                            end
                        end
                        wr.en       = 1'b1;
                        wr.new_addr = !res_reg.hit;
                        wr.slot     = slot;
                        m_data_next = {2'b00, TIME_W'(0), STR_W'(0), TYPE_W'(0),
                                       ADDR_W'(0), 1'b0, FILL_W'(count_next),
                                       evicted, res_reg.hit, SLOT_W'(slot)};
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

[tb/tb_address_table_oldest_eviction.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_address_table_oldest_eviction: self-checking bench for the address table
// Drives sighting and read requests on s_axis and tracks a shadow copy of the
// table: lookup, append, oldest-entry replacement with lowest-index tie break,
// and reads in and out of range. Every m_axis transfer is checked field by
// field against the oldest pending outcome. Both sides idle at random, with
// stretches at full rate.
// ----------------------------------------------------------------------------
module tb_address_table_oldest_eviction;
    import atoe_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4 * (TABLE_DEPTH + 3);
    localparam int RANDOM_ITEMS = 400;
    localparam int ADDR_POOL    = 24;

    typedef struct packed {
        logic [1:0]        pad;
        logic [RIDX_W-1:0] read_index;
        logic [TIME_W-1:0] time_now;
        logic [STR_W-1:0]  signal_strength;
        logic [TYPE_W-1:0] address_type;
        logic [ADDR_W-1:0] device_address;
    } request_t;

    typedef struct packed {
        logic [1:0]        pad;
        logic [TIME_W-1:0] read_last_seen;
        logic [STR_W-1:0]  read_strength;
        logic [TYPE_W-1:0] read_address_type;
        logic [ADDR_W-1:0] read_address;
        logic              read_valid;
        logic [FILL_W-1:0] fill_count;
        logic              was_evicted;
        logic              was_present;
        logic [SLOT_W-1:0] slot;
    } outcome_t;

    class address_table_tracker;
        logic [ADDR_W-1:0] stored_addr [TABLE_DEPTH];
        logic [TYPE_W-1:0] stored_type [TABLE_DEPTH];
        logic [STR_W-1:0]  stored_strength [TABLE_DEPTH];
        logic [TIME_W-1:0] stored_seen [TABLE_DEPTH];
        int                occupancy;
        outcome_t          expected_outcomes[$];
        int                errors;
        int                requests;
        int                results;
        int                hits;
        int                evictions;
        int                reads;
        int                in_range_reads;

        function void note_request(logic kind, request_t req);
            outcome_t o;
            int       slot;
            int       i;
            bit       hit;
            o = '0;
            slot = 0;
            hit = 1'b0;
            requests++;
            if (kind == KIND_SIGHT) begin
                for (i = 0; i < occupancy; i++) begin
                    if (!hit && stored_addr[i] == req.device_address) begin
                        hit = 1'b1;
                        slot = i;
                    end
                end
                if (hit) begin
                    hits++;
                end else if (occupancy >= TABLE_DEPTH) begin
                    for (i = 1; i < occupancy; i++) begin
                        if (stored_seen[i] < stored_seen[slot]) begin
                            slot = i;
                        end
                    end
                    o.was_evicted = 1'b1;
                    evictions++;
                end else begin
                    slot = occupancy;
                    occupancy++;
                end
                stored_addr[slot]     = req.device_address;
                stored_type[slot]     = req.address_type;
                stored_strength[slot] = req.signal_strength;
                stored_seen[slot]     = req.time_now;
                o.slot        = slot[SLOT_W-1:0];
                o.was_present = hit;
                o.fill_count  = occupancy[FILL_W-1:0];
            end else begin
                reads++;
                o.fill_count = occupancy[FILL_W-1:0];
                if (req.read_index < occupancy) begin
                    in_range_reads++;
                    o.read_valid        = 1'b1;
                    o.read_address      = stored_addr[req.read_index];
                    o.read_address_type = stored_type[req.read_index];
                    o.read_strength     = stored_strength[req.read_index];
                    o.read_last_seen    = stored_seen[req.read_index];
                end
            end
            expected_outcomes.push_back(o);
        endfunction

        function void compare_field(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_outcome(logic [OUT_TDATA_W-1:0] tdata);
            outcome_t want;
            outcome_t got;
            got = outcome_t'(tdata);
            results++;
            if (expected_outcomes.size() == 0) begin
                $error("result transfer with nothing pending: %h", tdata);
                errors++;
                return;
            end
            want = expected_outcomes.pop_front();
            compare_field("slot", want.slot, got.slot);
            compare_field("was_present", want.was_present, got.was_present);
            compare_field("was_evicted", want.was_evicted, got.was_evicted);
            compare_field("fill_count", want.fill_count, got.fill_count);
            compare_field("read_valid", want.read_valid, got.read_valid);
            compare_field("read_address", want.read_address, got.read_address);
            compare_field("read_address_type", want.read_address_type, got.read_address_type);
            compare_field("read_strength", want.read_strength, got.read_strength);
            compare_field("read_last_seen", want.read_last_seen, got.read_last_seen);
            compare_field("pad", want.pad, got.pad);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // device_address[47:0], address_type[49:48], signal_strength[57:50],
    // time_now[89:58], read_index[93:90], zero pad[95:94]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // kind[0]
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // slot[3:0], was_present[4], was_evicted[5], fill_count[10:6],
    // read_valid[11], read_address[59:12], read_address_type[61:60],
    // read_strength[69:62], read_last_seen[101:70], zero pad[103:102]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    address_table_tracker tracker = new;
    bit                   src_steady;
    bit                   sink_steady;
    int                   quiet_cycles;

    address_table_oldest_eviction u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] random_address();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic request_t random_request();
        request_t req;
        req.pad             = '0;
        req.device_address  = random_address();
        req.address_type    = TYPE_W'($urandom);
        req.signal_strength = STR_W'($urandom);
        req.time_now        = $urandom;
        req.read_index      = RIDX_W'($urandom);
        return req;
    endfunction

    task automatic send_request(input logic kind, input request_t req);
        int gap;
        if ($urandom_range(0, 31) == 0) begin
            src_steady = !src_steady;
        end
        gap = src_steady ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        s_axis_tuser  <= kind;
        do @(posedge aclk); while (!s_axis_tready);
        tracker.note_request(kind, req);
    endtask

    task automatic sight(input logic [ADDR_W-1:0] addr, input logic [TYPE_W-1:0] atype,
                         input logic [STR_W-1:0] strength, input logic [TIME_W-1:0] now);
        request_t req;
        req = random_request();
        req.device_address  = addr;
        req.address_type    = atype;
        req.signal_strength = strength;
        req.time_now        = now;
        send_request(KIND_SIGHT, req);
    endtask

    task automatic read_entry(input logic [RIDX_W-1:0] idx);
        request_t req;
        req = random_request();
        req.read_index = idx;
        send_request(KIND_READ, req);
    endtask

    task automatic run_directed();
        int i;
        read_entry(0);
        read_entry(15);
        sight('0, 2'd0, 8'h80, 32'h0);
        sight('1, 2'd3, 8'h7F, 32'hFFFF_FFFF);
        sight('0, 2'd2, 8'h00, 32'd100);
        read_entry(1);
        read_entry(2);
        // fill the table; slots 6 and 11 share the oldest time
        for (i = 2; i < TABLE_DEPTH; i++) begin
            sight(48'h0000_1000_0000 + i, TYPE_W'(i), STR_W'(i * 17),
                  (i == 6 || i == 11) ? 32'd50 : 32'd1000 + i);
        end
        read_entry(15);
        sight(48'h5555_AAAA_5555, 2'd1, 8'hFF, 32'd2000);
        sight(48'hAAAA_5555_AAAA, 2'd1, 8'h01, 32'd3000);
        read_entry(6);
    endtask

    task automatic run_random();
        logic [ADDR_W-1:0] pool [ADDR_POOL];
        logic [TIME_W-1:0] clock_ms;
        request_t          req;
        int                n;
        int                pick;
        clock_ms = '0;
        for (n = 0; n < ADDR_POOL; n++) begin
            pool[n] = random_address();
        end
        pool[0] = '0;
        pool[1] = '1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            req = random_request();
            if ($urandom_range(0, 3) == 0) begin
                send_request(KIND_READ, req);
            end else begin
                pick = $urandom_range(0, ADDR_POOL - 1);
                if ($urandom_range(0, 9) == 0) begin
                    pool[pick] = random_address();
                end
                req.device_address = pool[pick];
                case ($urandom_range(0, 2))
                    0: req.time_now = $urandom;
                    1: req.time_now = $urandom_range(0, 7);
                    default: begin
                        clock_ms += $urandom_range(0, 3);
                        req.time_now = clock_ms;
                    end
                endcase
                send_request(KIND_SIGHT, req);
            end
        end
    endtask

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                sink_steady = !sink_steady;
            end
            stall = sink_steady ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            tracker.check_outcome(m_axis_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("address_table_oldest_eviction: mismatch");
                $finish;
            end
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_SIGHT;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random();
        s_axis_tvalid <= 1'b0;
        while (tracker.expected_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d requests, %0d results: %0d hits, %0d replacements",
                 tracker.requests, tracker.results, tracker.hits, tracker.evictions);
        $display("table reads %0d, %0d of them inside the fill count",
                 tracker.reads, tracker.in_range_reads);
        if (tracker.errors == 0) begin
            $display("address_table_oldest_eviction: match");
        end else begin
            $display("address_table_oldest_eviction: mismatch");
        end
        $finish;
    end

endmodule
